// ===== rtl/address_to_block_range_lookup_core_assert.svh =====
// Assertion helpers for the checker in abrl_checker.sv.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ADDRESS_TO_BLOCK_RANGE_LOOKUP_CORE_ASSERT_SVH
`define ADDRESS_TO_BLOCK_RANGE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication.
`define ABRL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abrl: implication check failed");

// Next-cycle implication.
`define ABRL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abrl: next-cycle check failed");

`endif

// ===== rtl/abrl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package abrl_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int COUNT_W = 11;
   localparam int SLOT_W  = 10;
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 32;
   localparam int FUNC_W  = 16;
   localparam int INDEX_W = 10;

   // req_tdata layout, lowest bit first
   localparam int SLOT_LSB  = 0;
   localparam int START_LSB = SLOT_LSB + SLOT_W;
   localparam int SIZE_LSB  = START_LSB + ADDR_W;
   localparam int FUNC_LSB  = SIZE_LSB + SIZE_W;
   localparam int QADDR_LSB = FUNC_LSB + FUNC_W;
   localparam int DIR_BIT   = QADDR_LSB + ADDR_W;
   localparam int REQ_DATA_W = ((DIR_BIT + 1 + 7) / 8) * 8;

   // rsp_tdata layout: hit, block_index
   localparam int RSP_DATA_W = ((1 + INDEX_W + 7) / 8) * 8;

   localparam logic ACT_LOAD   = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   localparam logic DIR_FROM = 1'b0;
   localparam logic DIR_TO   = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic [FUNC_W-1:0] func;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/address_to_block_range_lookup_core.sv =====
// Block range lookup over a sorted table of code blocks.
// req channel: tuser is the action (load or lookup); tdata carries the entry fields
// for a load and the address and direction for a lookup. Every request gives one
// rsp transfer: tdata bit 0 is hit, bits 10:1 the table position (0 on a miss).
// csr channel writes entry_count and is always ready. The user must see that
// entry_count is written only while idle; the block does not enforce this. A
// request is taken only in the idle state; the block then works alone on it.
// A load goes straight to the result. A lookup runs a binary search through the
// single table read port, in at most ceil(log2(entry_count+1)) steps (11 for a
// full table), then reads the chosen entry: past its start the address is
// checked against its size, and direction "to" on an exact start walks back over
// equal-start entries of the same function. A stalled rsp holds its data; a
// finished request waits for the rsp register to free, returns to idle as its
// result is loaded into rsp, and can then take the next request.
// Reset clears the sequencer, rsp valid and entry_count; the table contents are
// not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module address_to_block_range_lookup_core #(
   parameter int TABLE_DEPTH = abrl_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // action
   input  wire logic                            req_tuser,
   // entry_slot, entry_start, entry_size, entry_function, query_address, direction
   input  wire logic [abrl_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // hit, block_index
   output logic [abrl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [abrl_pkg::COUNT_W-1:0]    csr_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SRCH = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_PICK = 3'd3;
   localparam logic [2:0] ST_SIZE = 3'd4;
   localparam logic [2:0] ST_WALK = 3'd5;
   localparam logic [2:0] ST_WCMP = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   abrl_pkg::entry_type mem [TABLE_DEPTH];
   abrl_pkg::entry_type rd_ff;

   logic [2:0]                    state_ff, state_in;
   logic [abrl_pkg::COUNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]              lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]              mid_ff, mid_in, pos_ff, pos_in;
   logic [abrl_pkg::ADDR_W-1:0]   addr_ff, addr_in, offset_ff, offset_in;
   logic                          dir_ff, dir_in;
   logic [abrl_pkg::FUNC_W-1:0]   fn_ff, fn_in;
   logic                          hit_ff, hit_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          rsp_valid_ff;
   logic [abrl_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                          req_xfer, rsp_load;
   logic                          wr_en, rd_en;
   logic [IDX_W-1:0]              rd_addr, wr_addr;
   abrl_pkg::entry_type           wr_data;
   logic [31:0]                   slot32, cnt32, usable32, idx32;
   logic [CNT_W-1:0]              usable, mid_calc;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign slot32   = 32'(req_tdata[abrl_pkg::SLOT_LSB +: abrl_pkg::SLOT_W]);
   assign wr_addr  = slot32[IDX_W-1:0];
   assign wr_data  = '{start: req_tdata[abrl_pkg::START_LSB +: abrl_pkg::ADDR_W],
                       size:  req_tdata[abrl_pkg::SIZE_LSB +: abrl_pkg::SIZE_W],
                       func:  req_tdata[abrl_pkg::FUNC_LSB +: abrl_pkg::FUNC_W]};
   assign wr_en    = req_xfer && (req_tuser == abrl_pkg::ACT_LOAD) &&
                     (slot32 < 32'(TABLE_DEPTH));

   // entry_count above the table depth is clamped
   assign cnt32    = 32'(count_ff);
   assign usable32 = (cnt32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt32;
   assign usable   = usable32[CNT_W-1:0];
   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign idx32       = 32'(idx_ff);
   assign rsp_data_in = abrl_pkg::RSP_DATA_W'({idx32[abrl_pkg::INDEX_W-1:0], hit_ff});
   assign rsp_load    = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      pos_in    = pos_ff;
      addr_in   = addr_ff;
      offset_in = offset_ff;
      dir_in    = dir_ff;
      fn_in     = fn_ff;
      hit_in    = hit_ff;
      idx_in    = idx_ff;
      rd_en     = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               addr_in = req_tdata[abrl_pkg::QADDR_LSB +: abrl_pkg::ADDR_W];
               dir_in  = req_tdata[abrl_pkg::DIR_BIT];
               hit_in  = 1'b0;
               idx_in  = '0;
               lo_in   = '0;
               hi_in   = usable;
               if (req_tuser == abrl_pkg::ACT_LOAD) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc[IDX_W-1:0];
               rd_en    = 1'b1;
               rd_addr  = mid_calc[IDX_W-1:0];
               state_in = ST_CMP;
            end else if (lo_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               pos_in   = IDX_W'(lo_ff - 1'b1);
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(lo_ff - 1'b1);
               state_in = ST_PICK;
            end
         end
         ST_CMP: begin
            if (addr_ff < rd_ff.start) begin
               hi_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + 1'b1;
            end
            state_in = ST_SRCH;
         end
         ST_PICK: begin
            // search guarantees start <= address here
            if (addr_ff > rd_ff.start) begin
               offset_in = addr_ff - rd_ff.start;
               state_in  = ST_SIZE;
            end else begin
               hit_in = 1'b1;
               idx_in = pos_ff;
               fn_in  = rd_ff.func;
               state_in = (dir_ff == abrl_pkg::DIR_TO) ? ST_WALK : ST_DONE;
            end
         end
         ST_SIZE: begin
            if ((offset_ff < 64'(rd_ff.size)) ||
                ((offset_ff == 64'(rd_ff.size)) && (dir_ff == abrl_pkg::DIR_TO))) begin
               hit_in = 1'b1;
               idx_in = pos_ff;
            end
            state_in = ST_DONE;
         end
         ST_WALK: begin
            if (pos_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = pos_ff - 1'b1;
               state_in = ST_WCMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WCMP: begin
            // step back over equal starts owned by the same function
            if ((rd_ff.start == addr_ff) && (rd_ff.func == fn_ff)) begin
               pos_in   = pos_ff - 1'b1;
               idx_in   = pos_ff - 1'b1;
               state_in = ST_WALK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      addr_ff   <= addr_in;
      offset_ff <= offset_in;
      dir_ff    <= dir_in;
      fn_ff     <= fn_in;
      hit_ff    <= hit_in;
      idx_ff    <= idx_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/abrl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "address_to_block_range_lookup_core_assert.svh"

module abrl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [abrl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result keeps its data
   `ABRL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // one request at a time: busy right after a request transfer
   `ABRL_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready)

   // a miss or a load reports position zero
   `ABRL_ASSERT_IMPLY(a_miss_zero, rsp_tvalid && !rsp_tdata[0],
      rsp_tdata[abrl_pkg::INDEX_W:1] == '0)

   // nothing pending out of reset
   `ABRL_ASSERT_IMPLY(a_reset_empty, $past(reset), !rsp_tvalid && req_tready)

endmodule

bind address_to_block_range_lookup_core abrl_checker u_abrl_checker (.*);

`default_nettype wire

// ===== test/block_lookup_checker.sv =====
`timescale 1ns / 1ps

module block_lookup_checker
   import abrl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [COUNT_W-1:0]    csr_data,
   output int                    mismatch_count,
   output int                    answers_due
);

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] index;
   } answer_type;

   logic [ADDR_W-1:0]  start_mem [TABLE_DEPTH_DEF];
   logic [SIZE_W-1:0]  size_mem  [TABLE_DEPTH_DEF];
   logic [FUNC_W-1:0]  func_mem  [TABLE_DEPTH_DEF];
   logic [COUNT_W-1:0] live_count;
   answer_type         expected_answers [$];
   int                 faults = 0;

   // Binary search for the last entry whose start is not above addr, then the size check or the walk back.
   function automatic answer_type locate_block(input logic [ADDR_W-1:0] addr,
                                               input logic dir);
      int unsigned       lo, hi, mid, pos;
      logic [ADDR_W-1:0] offset;
      logic [FUNC_W-1:0] owner;
      answer_type        ans;
      ans = '0;
      lo = 0;
      hi = (live_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : live_count;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (addr < start_mem[mid]) hi = mid;
         else lo = mid + 1;
      end
      if (lo == 0) return ans;
      pos = lo - 1;
      if (addr > start_mem[pos]) begin
         // distance test, so blocks running past the top of memory still match
         offset = addr - start_mem[pos];
         if (offset < 64'(size_mem[pos]) ||
             (offset == 64'(size_mem[pos]) && dir == DIR_TO)) begin
            ans.hit = 1'b1;
            ans.index = pos[INDEX_W-1:0];
         end
         return ans;
      end
      if (dir == DIR_TO) begin
         owner = func_mem[pos];
         while (pos > 0 && start_mem[pos-1] == addr && func_mem[pos-1] == owner) pos--;
      end
      ans.hit = 1'b1;
      ans.index = pos[INDEX_W-1:0];
      return ans;
   endfunction

   always @(posedge clock) begin : monitor
      answer_type         seen, want;
      logic [SLOT_W-1:0]  slot;
      if (reset) begin
         live_count = '0;
         expected_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.hit = rsp_tdata[0];
            seen.index = rsp_tdata[INDEX_W:1];
            if (expected_answers.size() == 0) begin
               $error("rsp transfer with nothing outstanding: hit %0b block_index %0d",
                      seen.hit, seen.index);
               faults++;
            end else begin
               want = expected_answers.pop_front();
               if (seen.hit !== want.hit) begin
                  $error("hit: expected %0b, got %0b", want.hit, seen.hit);
                  faults++;
               end
               if (seen.index !== want.index) begin
                  $error("block_index: expected %0d, got %0d", want.index, seen.index);
                  faults++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_LOAD) begin
               slot = req_tdata[SLOT_LSB +: SLOT_W];
               start_mem[slot] = req_tdata[START_LSB +: ADDR_W];
               size_mem[slot] = req_tdata[SIZE_LSB +: SIZE_W];
               func_mem[slot] = req_tdata[FUNC_LSB +: FUNC_W];
               expected_answers = {expected_answers, answer_type'('0)};
            end else begin
               expected_answers = {expected_answers,
                                   locate_block(req_tdata[QADDR_LSB +: ADDR_W],
                                                req_tdata[DIR_BIT])};
            end
         end
         if (csr_valid && csr_ready) live_count = csr_data;
      end
      mismatch_count <= faults;
      answers_due <= expected_answers.size();
   end

endmodule

// ===== test/address_to_block_range_lookup_core_tb.sv =====
`timescale 1ns / 1ps

module address_to_block_range_lookup_core_tb;
   import abrl_pkg::*;

   localparam int RANDOM_ITEMS = 750;
   localparam int STALL_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 300;
   localparam int COUNT_TOP    = (1 << COUNT_W) - 1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = ACT_LOAD;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_W-1:0]    csr_data = '0;
   int                    mismatch_count;
   int                    answers_due;

   // stimulus copy of the table, used to aim lookups at block edges
   logic [ADDR_W-1:0] aim_start [TABLE_DEPTH_DEF];
   logic [SIZE_W-1:0] aim_size  [TABLE_DEPTH_DEF];
   int                filled = 0;   // written prefix of the table
   int                sent_items = 0;
   bit                no_gaps = 1'b0;
   bit                hold_request = 1'b0;

   initial forever #2 clock = ~clock;

   address_to_block_range_lookup_core #(.TABLE_DEPTH(TABLE_DEPTH_DEF)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   block_lookup_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_payload();
      logic [REQ_DATA_W-1:0] data;
      for (int i = 0; i < REQ_DATA_W; i += 32) data[i +: 32] = $urandom;
      for (int i = DIR_BIT + 1; i < REQ_DATA_W; i++) data[i] = 1'b0;
      return data;
   endfunction

   // slots that a full-depth search visits for addresses below the first entry
   // or at or above the second to last entry, plus the walk neighbor
   function automatic bit on_search_rim(input int s);
      int gap;
      gap = TABLE_DEPTH_DEF - s;
      return ((s & (s - 1)) == 0) || ((gap & (gap - 1)) == 0) ||
             (s == TABLE_DEPTH_DEF - 3);
   endfunction

   // valid stays high between back-to-back transfers
   task automatic send_req(input logic act, input logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   task automatic load_entry(input int slot, input logic [ADDR_W-1:0] start,
                             input logic [SIZE_W-1:0] size, input logic [FUNC_W-1:0] func);
      logic [REQ_DATA_W-1:0] data;
      data = random_payload();
      data[SLOT_LSB +: SLOT_W] = SLOT_W'(slot);
      data[START_LSB +: ADDR_W] = start;
      data[SIZE_LSB +: SIZE_W] = size;
      data[FUNC_LSB +: FUNC_W] = func;
      aim_start[slot] = start;
      aim_size[slot] = size;
      if (slot == filled) filled++;
      send_req(ACT_LOAD, data);
   endtask

   task automatic look_up_address(input logic [ADDR_W-1:0] addr, input logic dir);
      logic [REQ_DATA_W-1:0] data;
      data = random_payload();
      data[QADDR_LSB +: ADDR_W] = addr;
      data[DIR_BIT] = dir;
      send_req(ACT_LOOKUP, data);
   endtask

   // Drop valid and wait for every outstanding result before touching csr.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      csr_valid <= 1'b1;
      csr_data <= COUNT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sorted table in slots 0..n-1; runs of equal starts, often with the same owner.
   task automatic build_table(input int n);
      logic [ADDR_W-1:0] at, step;
      logic [SIZE_W-1:0] size;
      logic [FUNC_W-1:0] owner;
      int                spacing;
      spacing = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
         0: at = '0;
         1: at = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20));
         2: at = {$urandom, $urandom};
         default: at = 64'($urandom_range(0, 1000));
      endcase
      owner = FUNC_W'($urandom);
      for (int k = 0; k < n; k++) begin
         if (k > 0) begin
            if ($urandom_range(0, 4) == 0) step = '0;
            else case (spacing)
               0: step = 64'($urandom_range(1, 8));
               1: step = 64'($urandom_range(1, 65536));
               default: step = {24'b0, 8'($urandom), $urandom};
            endcase
            // saturate at the top of the address space to keep the order
            at = (at + step < at) ? 64'hFFFF_FFFF_FFFF_FFFF : at + step;
         end
         if ($urandom_range(0, 1) == 0) owner = FUNC_W'($urandom);
         case ($urandom_range(0, 4))
            0: size = '0;
            1: size = SIZE_W'($urandom_range(1, 16));
            2: size = SIZE_W'($urandom_range(1, 4096));
            3: size = $urandom;
            default: size = '1;
         endcase
         load_entry(k, at, size, owner);
      end
   endtask

   // Ascending starts on the search rim only, for counts at and above the depth.
   task automatic build_rim();
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] size;
      base = 64'($urandom_range(1, 1 << 30));
      for (int s = 0; s < TABLE_DEPTH_DEF; s++) begin
         if (on_search_rim(s)) begin
            size = ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(0, 16)) : $urandom;
            load_entry(s, base + 64'(s) * 64'h1000, size, FUNC_W'($urandom));
         end
      end
   endtask

   // Lookups below the first entry or at and above the second to last one.
   task automatic probe_rim(input int lookups);
      logic [ADDR_W-1:0] low_start, top_start, next_start, addr;
      logic [SIZE_W-1:0] size;
      low_start = aim_start[0];
      next_start = aim_start[TABLE_DEPTH_DEF-2];
      top_start = aim_start[TABLE_DEPTH_DEF-1];
      size = aim_size[TABLE_DEPTH_DEF-1];
      repeat (lookups) begin
         case ($urandom_range(0, 7))
            0: addr = '0;
            1: addr = low_start - 1;
            2: addr = next_start;
            3: addr = next_start + 1;
            4: addr = top_start;
            5: addr = top_start + size;
            6: addr = top_start + 64'($urandom_range(0, size));
            default: addr = '1;
         endcase
         look_up_address(addr, $urandom_range(0, 1) ? DIR_TO : DIR_FROM);
      end
   endtask

   // Lookups aimed around entries 0..n-1, with a few stray loads mixed in.
   task automatic probe_table(input int n, input int lookups);
      int                k, top_slot;
      logic [ADDR_W-1:0] base, addr;
      logic [SIZE_W-1:0] size;
      logic              dir;
      repeat (lookups) begin
         if ($urandom_range(0, 9) == 0) begin
            // may break the ordering or extend the written prefix
            top_slot = (filled < TABLE_DEPTH_DEF) ? filled : TABLE_DEPTH_DEF - 1;
            load_entry($urandom_range(0, top_slot), {$urandom, $urandom}, $urandom,
                       FUNC_W'($urandom));
         end else begin
            k = $urandom_range(0, n - 1);
            base = aim_start[k];
            size = aim_size[k];
            case ($urandom_range(0, 11))
               0: addr = base - 1;
               1, 2: addr = base;
               3: addr = base + 1;
               4: addr = base + size - 1;
               5, 6: addr = base + size;
               7: addr = base + size + 1;
               8: addr = base + 64'($urandom_range(0, size));
               9: addr = '0;
               10: addr = '1;
               default: addr = {$urandom, $urandom};
            endcase
            dir = $urandom_range(0, 1) ? DIR_TO : DIR_FROM;
            look_up_address(addr, dir);
         end
      end
   endtask

   // rsp side: random ready pattern, plus one long hold while requests keep coming
   initial begin : rsp_side
      int run, gap;
      bit hold_done;
      hold_done = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            run = no_gaps ? 1 : $urandom_range(1, 12);
            rsp_tready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int phase, first, n, count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty table
      look_up_address(64'h0, DIR_FROM);
      look_up_address(64'hFFFF_FFFF_FFFF_FFFF, DIR_TO);
      load_entry(0, 64'h10, 32'h100, 16'h0001);
      load_entry(1, 64'h2000, 32'h10, 16'h0005);
      load_entry(2, 64'h2000, 32'h0, 16'h0007);
      load_entry(3, 64'h2000, 32'h20, 16'h0007);
      load_entry(4, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 16'hFFFF);
      settle();
      write_count(5);
      look_up_address(64'h0, DIR_FROM);      // below the first block
      look_up_address(64'h10, DIR_FROM);     // exact start
      look_up_address(64'h10F, DIR_FROM);
      look_up_address(64'h110, DIR_FROM);    // block end, source side
      look_up_address(64'h110, DIR_TO);      // block end, target side
      look_up_address(64'h2000, DIR_FROM);
      look_up_address(64'h2000, DIR_TO);     // walks back over the same owner
      look_up_address(64'h2020, DIR_TO);
      look_up_address(64'h2021, DIR_TO);
      look_up_address(64'h1FFF, DIR_TO);     // between blocks
      look_up_address(64'hFFFF_FFFF_FFFF_FFFF, DIR_FROM); // block runs past the top
      settle();
      write_count(2);
      look_up_address(64'h2000, DIR_TO);
      settle();

      // counts at and above the depth, searched along the rim of the table
      build_rim();
      settle();
      write_count(TABLE_DEPTH_DEF);
      probe_rim(30);
      settle();
      write_count(COUNT_TOP);
      probe_rim(15);
      settle();
      write_count($urandom_range(TABLE_DEPTH_DEF + 1, COUNT_TOP - 1));
      probe_rim(10);
      settle();

      phase = 0;
      first = sent_items;
      while (sent_items - first < RANDOM_ITEMS) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
         no_gaps = ($urandom_range(0, 3) == 0);
         build_table(n);
         settle();
         case ($urandom_range(0, 5))
            0: count = $urandom_range(0, n);
            1: count = $urandom_range(0, filled);
            default: count = n;
         endcase
         write_count(count);
         if (phase == 1) hold_request = 1'b1;
         probe_table(n, (phase == 1) ? 40 : $urandom_range(8, 30));
         settle();
         phase++;
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && answers_due == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/abrl_pkg.sv
rtl/address_to_block_range_lookup_core.sv
rtl/abrl_checker.sv
test/block_lookup_checker.sv
test/address_to_block_range_lookup_core_tb.sv
